### hw/rtl/asps_pkg.sv
package asps_pkg;

   localparam int WIN_DEPTH = 12;
   localparam int POS_SPAN  = 9;

   typedef logic [7:0]  byte_type;
   typedef logic [3:0]  state_digit_type;
   typedef logic [31:0] csr_data_type;
   typedef logic [2:0]  sleep_kind_type;
   typedef logic signed [7:0] room_type;

   typedef enum logic {
      CSR_SLEEP_STATE   = 1'b0,
      CSR_STREAM_LENGTH = 1'b1
   } csr_index_type;

   localparam byte_type NAME_OP      = 8'h08;
   localparam byte_type UNDERSCORE   = 8'h5F;
   localparam byte_type DIGIT_BASE   = 8'h30;
   localparam byte_type PACKAGE_OP   = 8'h12;
   localparam byte_type ZERO_OP      = 8'h00;
   localparam byte_type ONE_OP       = 8'h01;
   localparam byte_type BYTE_PREFIX  = 8'h0A;
   localparam byte_type WORD_PREFIX  = 8'h0B;
   localparam byte_type DWORD_PREFIX = 8'h0C;

   localparam state_digit_type SLEEP_STATE_RESET   = 4'd5;
   localparam csr_data_type    STREAM_LENGTH_RESET = 32'd36;

   // room = bytes left in the stream past the candidate start, clamped
   localparam room_type ROOM_MAX = 8'sd100;
   localparam room_type ROOM_MIN = -8'sd100;

   typedef struct packed {
      logic           hit;
      sleep_kind_type ty;
   } pos_result_type;

endpackage

### hw/rtl/asps_req_if.sv
interface asps_req_if;
   import asps_pkg::*;

   logic     valid;
   logic     ready;
   byte_type data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

### hw/rtl/asps_rsp_if.sv
interface asps_rsp_if;
   import asps_pkg::*;

   logic           valid;
   logic           ready;
   logic           found;
   sleep_kind_type sleep_kind;

   modport source (output valid, output found, output sleep_kind, input ready);
   modport sink   (input valid, input found, input sleep_kind, output ready);
endinterface

### hw/rtl/asps_pos_check.sv
module asps_pos_check (
   input  asps_pkg::byte_type       win_bytes [asps_pkg::POS_SPAN],
   input  asps_pkg::byte_type       name_char,
   input  asps_pkg::room_type       room,
   input  logic                     pos_ok,
   output asps_pkg::pos_result_type result
);
   import asps_pkg::*;

   logic [5:0] pkg_len;
   room_type   pkg_end;
   logic       head_ok;
   logic       len_ok;
   logic       int_ok;
   sleep_kind_type int_ty;

   assign pkg_len = win_bytes[6][5:0];
   assign pkg_end = $signed({2'b00, pkg_len}) + 8'sd7;

   assign head_ok = (win_bytes[0] == NAME_OP)    && (win_bytes[1] == UNDERSCORE) &&
                    (win_bytes[2] == name_char)  && (win_bytes[3] == UNDERSCORE) &&
                    (win_bytes[4] == UNDERSCORE) && (win_bytes[5] == PACKAGE_OP);

   assign len_ok = (room > 8'sd8) && (pkg_len != 6'd0) && (pkg_end <= room);

   always_comb begin
      int_ok = 1'b0;
      int_ty = win_bytes[8][2:0];
      unique case (win_bytes[7])
         ZERO_OP: begin
            int_ok = 1'b1;
            int_ty = 3'd0;
         end
         ONE_OP: begin
            int_ok = 1'b1;
            int_ty = 3'd1;
         end
         BYTE_PREFIX:  int_ok = 1'b1;
         WORD_PREFIX:  int_ok = (room >= 8'sd10);
         DWORD_PREFIX: int_ok = (room >= 8'sd12);
         default:      int_ok = 1'b0;
      endcase
   end

   assign result.hit = pos_ok && head_ok && len_ok && int_ok;
   assign result.ty  = int_ty;

endmodule

### hw/rtl/aml_sleep_package_scanner_top.sv
// A stream's last byte passes through the input register, then the result register, before its result is offered.
// Throughput: one byte per cycle unless a stream-ending byte waits; bytes that do not end a stream never stall.
// A stream-ending byte waits in the input register only while a prior result is unread.
// Reset is synchronous and active high: scan state clears, sleep_state returns to 5 and
// stream_length to 36; no clearing pass is needed.
module aml_sleep_package_scanner_top (
   input  logic                   clock,
   input  logic                   reset,
   asps_req_if.sink               req,
   asps_rsp_if.source             rsp,
   input  logic                   csr_we,
   input  asps_pkg::csr_index_type csr_index,
   input  asps_pkg::csr_data_type csr_wdata
);
   import asps_pkg::*;

   localparam int EXT_DEPTH = WIN_DEPTH + POS_SPAN - 1;

   // configuration
   state_digit_type sleep_state_ff;
   csr_data_type    stream_length_ff;

   // input register
   logic     in_vld_ff;
   byte_type in_byte_ff;

   // scan state
   byte_type       win_ff [WIN_DEPTH];
   logic [31:0]    count_ff;
   logic           match_seen_ff;
   sleep_kind_type match_type_ff;

   // result register
   logic           rsp_vld_ff;
   logic           rsp_found_ff;
   sleep_kind_type rsp_type_ff;

   // datapath
   byte_type        win_in [WIN_DEPTH];
   byte_type        ext_win [EXT_DEPTH];
   logic [32:0]     n_in;
   logic signed [33:0] gap;
   room_type        gap_clamped;
   logic [3:0]      n_sat;
   byte_type        name_char;
   pos_result_type  pos_res [WIN_DEPTH];
   logic            stream_end;
   logic            fire;
   logic            found_in;
   sleep_kind_type  type_in;

   // Shift the new byte into the newest slot; slot 0 is the oldest.
   always_comb begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
         win_in[i] = win_ff[i + 1];
      end
      win_in[WIN_DEPTH - 1] = in_byte_ff;
   end

   // Bytes past the newest one read as zero.
   always_comb begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
         ext_win[i] = win_in[i];
      end
      for (int i = WIN_DEPTH; i < EXT_DEPTH; i++) begin
         ext_win[i] = '0;
      end
   end

   assign n_in = {1'b0, count_ff} + 33'd1;

   // Bytes left beyond the newest one; one wide subtract, then clamp so that
   // every per-position bound check is a narrow compare.
   assign gap = $signed({2'b00, stream_length_ff}) - $signed({1'b0, n_in});

   always_comb begin
      if (gap > 34'sd100) begin
         gap_clamped = ROOM_MAX;
      end else if (gap < -34'sd100) begin
         gap_clamped = ROOM_MIN;
      end else begin
         gap_clamped = gap[7:0];
      end
   end

   // A step ends the stream once the count reaches or passes the length.
   assign stream_end = (gap <= 34'sd0);

   assign n_sat     = (n_in >= 33'(WIN_DEPTH)) ? 4'(WIN_DEPTH) : n_in[3:0];
   assign name_char = DIGIT_BASE + {4'b0000, sleep_state_ff};

   // One checker per window slot. Slot s starts at address n - 12 + s; it is a
   // real position only when that address is not negative.
   for (genvar s = 0; s < WIN_DEPTH; s++) begin : g_pos
      byte_type pos_bytes [POS_SPAN];
      room_type pos_room;
      logic     pos_ok;

      for (genvar k = 0; k < POS_SPAN; k++) begin : g_byte
         assign pos_bytes[k] = ext_win[s + k];
      end

      assign pos_room = gap_clamped + 8'(WIN_DEPTH - s);
      assign pos_ok   = (n_sat >= 4'(WIN_DEPTH - s));

      asps_pos_check u_check (
         .win_bytes (pos_bytes),
         .name_char (name_char),
         .room      (pos_room),
         .pos_ok    (pos_ok),
         .result    (pos_res[s])
      );
   end

   // Final-step result: an earlier match holds, else the lowest hit slot wins.
   // On other steps only slot 0 is fully arrived and gets recorded.
   always_comb begin
      found_in = match_seen_ff;
      type_in  = match_type_ff;
      if (!match_seen_ff) begin
         for (int s = WIN_DEPTH - 1; s >= 0; s--) begin
            if (pos_res[s].hit) begin
               found_in = 1'b1;
               type_in  = pos_res[s].ty;
            end
         end
      end
   end

   // Advance the held byte unless it ends a stream and the result slot is full and not being read.
   assign fire      = in_vld_ff && (!stream_end || !rsp_vld_ff || rsp.ready);
   assign req.ready = !in_vld_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         sleep_state_ff   <= SLEEP_STATE_RESET;
         stream_length_ff <= STREAM_LENGTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SLEEP_STATE:   sleep_state_ff   <= csr_wdata[3:0];
            CSR_STREAM_LENGTH: stream_length_ff <= csr_wdata;
            default:           sleep_state_ff   <= sleep_state_ff;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req.ready) begin
         in_vld_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_byte_ff <= req.data_byte;
      end
   end

   // scan state: drop everything at stream end, else shift and record slot 0
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN_DEPTH; i++) begin
            win_ff[i] <= '0;
         end
         count_ff      <= '0;
         match_seen_ff <= 1'b0;
         match_type_ff <= '0;
      end else if (fire) begin
         if (stream_end) begin
            for (int i = 0; i < WIN_DEPTH; i++) begin
               win_ff[i] <= '0;
            end
            count_ff      <= '0;
            match_seen_ff <= 1'b0;
            match_type_ff <= '0;
         end else begin
            win_ff   <= win_in;
            count_ff <= n_in[31:0];
            if (!match_seen_ff && pos_res[0].hit) begin
               match_seen_ff <= 1'b1;
               match_type_ff <= pos_res[0].ty;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (fire && stream_end) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && stream_end) begin
         rsp_found_ff <= found_in;
         rsp_type_ff  <= found_in ? type_in : '0;
      end
   end

   assign rsp.valid      = rsp_vld_ff;
   assign rsp.found      = rsp_found_ff;
   assign rsp.sleep_kind = rsp_type_ff;

endmodule
